>>> rtl/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a must bring condition c in the same cycle.
`define CHSR_ASSERT_SAME(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("chsr assertion failed");

// Condition a must bring condition c in the next cycle.
`define CHSR_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("chsr assertion failed");

`endif

>>> rtl/chsr_pkg.sv
package chsr_pkg;
	localparam int SAMPLE_W = 24;
	localparam int POS_W = 21;
	localparam int RATIO_W = 21;
	localparam int CC_W = 2;
	localparam int MAX_RESULTS = 16;
	localparam int ACC_W = 32;
	localparam int PROD_W = 54;

	localparam logic [0:0] OP_FRAME = 1'b0;
	localparam logic [0:0] OP_FLUSH = 1'b1;

	localparam logic [0:0] REG_RATIO = 1'b0;
	localparam logic [0:0] REG_CHANNELS = 1'b1;

	// Request classes handed from the front to the back.
	localparam logic [1:0] CLS_FRAME = 2'd0;
	localparam logic [1:0] CLS_FLUSH = 2'd1;
	localparam logic [1:0] CLS_UNITY = 2'd2;

	// Lane datapath commands.
	localparam logic [1:0] LANE_HOLD = 2'd0;
	localparam logic [1:0] LANE_START = 2'd1;
	localparam logic [1:0] LANE_STEP_B = 2'd2;
	localparam logic [1:0] LANE_STEP_C = 2'd3;

	typedef struct packed {
		logic [1:0] cls;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} chsr_item_t;
endpackage

>>> rtl/chsr_front.sv
module chsr_front #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [0:0] operation,
	input logic signed [chsr_pkg::SAMPLE_W-1:0] left_sample,
	input logic signed [chsr_pkg::SAMPLE_W-1:0] right_sample,
	input logic [chsr_pkg::RATIO_W-1:0] ratio,
	output logic q_valid,
	output chsr_pkg::chsr_item_t q_item,
	input logic q_pop
);
	import chsr_pkg::*;

	localparam logic [25:0] ONE_W = 26'(1) << FRAC_BITS;

	chsr_item_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	chsr_item_t item;
	logic push;

	always_comb begin
		item.left = left_sample;
		item.right = right_sample;
		if (operation == OP_FLUSH) begin
			item.cls = CLS_FLUSH;
		end else if ({5'b0, ratio} == ONE_W) begin
			item.cls = CLS_UNITY;
		end else begin
			item.cls = CLS_FRAME;
		end
	end

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (count_q != 2'd0);
	assign q_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

>>> rtl/chsr_lane.sv
module chsr_lane #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic [1:0] op,
	input logic signed [chsr_pkg::SAMPLE_W-1:0] taps [4],
	input logic [chsr_pkg::POS_W-1:0] pos,
	output logic signed [chsr_pkg::SAMPLE_W-1:0] result
);
	import chsr_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0] b2_q;
	logic signed [ACC_W-1:0] c2_q;
	logic signed [SAMPLE_W-1:0] x0_q;
	logic signed [ACC_W-1:0] xm1e, x0e, x1e, x2e;
	logic signed [ACC_W-1:0] a2, b2, c2;
	logic signed [ACC_W-1:0] shifted, t, m_a;
	logic signed [PROD_W-1:0] prod_n;
	logic signed [63:0] fin, rnd;

	always_comb begin
		xm1e = ACC_W'(taps[0]);
		x0e = ACC_W'(taps[1]);
		x1e = ACC_W'(taps[2]);
		x2e = ACC_W'(taps[3]);
		a2 = 3 * (x0e - x1e) - xm1e + x2e;
		b2 = 4 * x1e + 2 * xm1e - 5 * x0e - x2e;
		c2 = x1e - xm1e;
		shifted = ACC_W'(prod_s1 >>> FRAC_BITS);
		unique case (op)
			LANE_STEP_B: t = shifted + b2_q;
			LANE_STEP_C: t = shifted + c2_q;
			LANE_START, LANE_HOLD: t = shifted;
			default: t = shifted;
		endcase
		m_a = (op == LANE_START) ? a2 : t;
		prod_n = PROD_W'(m_a) * PROD_W'($signed({1'b0, pos}));
		// Final step: add the scaled center tap and round half up.
		fin = 64'(prod_s1) + (64'(x0_q) <<< (FRAC_BITS + 1)) + (64'(1) <<< FRAC_BITS);
		rnd = fin >>> (FRAC_BITS + 1);
		if (rnd > 64'sd8388607) begin
			result = 24'sh7FFFFF;
		end else if (rnd < -64'sd8388608) begin
			result = 24'sh800000;
		end else begin
			result = SAMPLE_W'(rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (op != LANE_HOLD) begin
			prod_s1 <= prod_n;
		end
		if (op == LANE_START) begin
			b2_q <= b2;
			c2_q <= c2;
			x0_q <= taps[1];
		end
	end
endmodule

>>> rtl/chsr_back.sv
module chsr_back #(
	parameter int CHANNELS = 2,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input chsr_pkg::chsr_item_t q_item,
	output logic q_pop,
	input logic [chsr_pkg::RATIO_W-1:0] ratio,
	input logic mono,
	input logic reprime,
	output logic out_valid,
	input logic out_ready,
	output logic signed [chsr_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [chsr_pkg::SAMPLE_W-1:0] right_out,
	output logic last_of_run
);
	import chsr_pkg::*;

	localparam logic [25:0] ONE_W = 26'(1) << FRAC_BITS;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_M1 = 3'd2;
	localparam logic [2:0] ST_M2 = 3'd3;
	localparam logic [2:0] ST_M3 = 3'd4;
	localparam logic [2:0] ST_FIN = 3'd5;
	localparam logic [2:0] ST_PASS = 3'd6;

	logic [2:0] state_q;
	logic [POS_W-1:0] pos_q;
	logic [1:0] prime_q;
	logic [3:0] count_q;
	logic signed [SAMPLE_W-1:0] hist_q [CHANNELS][4];
	logic signed [SAMPLE_W-1:0] res [CHANNELS];
	logic signed [SAMPLE_W-1:0] smp [CHANNELS];
	logic out_valid_q;
	logic signed [SAMPLE_W-1:0] left_q, right_q;
	logic last_q;
	logic [1:0] lane_op;
	logic slot_free;
	logic below_one;
	logic [POS_W:0] np;
	logic [POS_W-1:0] np_sat;
	logic np_below;
	logic signed [SAMPLE_W-1:0] pass_r;
	logic fin_go;
	logic pass_go;

	assign slot_free = !out_valid_q || out_ready;
	assign below_one = {5'b0, pos_q} < ONE_W;
	assign np = {1'b0, pos_q} + {1'b0, ratio};
	assign np_sat = np[POS_W] ? {POS_W{1'b1}} : np[POS_W-1:0];
	assign np_below = {5'b0, np_sat} < ONE_W;
	assign fin_go = !reprime && (state_q == ST_FIN) && slot_free;
	assign pass_go = !reprime && (state_q == ST_PASS) && slot_free;
	// A pass-through request stays at the queue head until the output register is free.
	assign q_pop = ((state_q == ST_IDLE) && q_valid && q_item.cls != CLS_UNITY) || pass_go;
	assign pass_r = mono ? q_item.left : q_item.right;

	always_comb begin
		unique case (state_q)
			ST_M1: lane_op = LANE_START;
			ST_M2: lane_op = LANE_STEP_B;
			ST_M3: lane_op = LANE_STEP_C;
			ST_IDLE, ST_CHECK, ST_FIN, ST_PASS: lane_op = LANE_HOLD;
			default: lane_op = LANE_HOLD;
		endcase
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		assign smp[c] = (c == 0) ? q_item.left : q_item.right;
		chsr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk(clk),
			.op(lane_op),
			.taps(hist_q[c]),
			.pos(pos_q),
			.result(res[c])
		);

		always_ff @(posedge clk) begin
			if (state_q == ST_IDLE && q_valid && q_item.cls == CLS_FRAME) begin
				if (prime_q != 2'd0) begin
					unique case (prime_q)
						2'd3: begin
							hist_q[c][0] <= '0;
							hist_q[c][1] <= smp[c];
						end
						2'd2: hist_q[c][2] <= smp[c];
						2'd1: hist_q[c][3] <= smp[c];
						default: hist_q[c][3] <= smp[c];
					endcase
				end else begin
					hist_q[c][0] <= hist_q[c][1];
					hist_q[c][1] <= hist_q[c][2];
					hist_q[c][2] <= hist_q[c][3];
					hist_q[c][3] <= smp[c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pass_go) begin
			left_q <= q_item.left;
			right_q <= pass_r;
			last_q <= 1'b1;
		end else if (fin_go) begin
			left_q <= res[0];
			right_q <= (CHANNELS == 1 || mono) ? res[0] : res[CHANNELS-1];
			last_q <= !(np_below && count_q != 4'(MAX_RESULTS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			prime_q <= 2'd3;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go || pass_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (reprime) begin
				prime_q <= 2'd3;
				pos_q <= '0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (q_valid) begin
							unique case (q_item.cls)
								CLS_FLUSH: begin
									prime_q <= 2'd3;
									pos_q <= '0;
								end
								CLS_UNITY: state_q <= ST_PASS;
								default: begin
									count_q <= '0;
									if (prime_q != 2'd0) begin
										prime_q <= prime_q - 2'd1;
										if (prime_q == 2'd1) begin
											pos_q <= '0;
											state_q <= ST_CHECK;
										end
									end else begin
										pos_q <= below_one ? '0 : POS_W'({5'b0, pos_q} - ONE_W);
										state_q <= ST_CHECK;
									end
								end
							endcase
						end
					end
					ST_CHECK: state_q <= below_one ? ST_M1 : ST_IDLE;
					ST_M1: state_q <= ST_M2;
					ST_M2: state_q <= ST_M3;
					ST_M3: state_q <= ST_FIN;
					ST_FIN: begin
						if (slot_free) begin
							pos_q <= np_sat;
							count_q <= count_q + 4'd1;
							// Stop once the position reaches one or the burst is full.
							if (np_below && count_q != 4'(MAX_RESULTS - 1)) begin
								state_q <= ST_M1;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
					ST_PASS: begin
						if (slot_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign left_out = left_q;
	assign right_out = right_q;
	assign last_of_run = last_q;
endmodule

>>> rtl/cubic_hermite_stream_resampler_top.sv
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    operation, left_sample, right_sample
// out      out  out_valid/out_ready  left_out, right_out, last_of_run
// cfg      in   cfg_write            cfg_index, cfg_data
// Each result passes through the lane datapath as three multiply steps
// through one shared multiplier per channel and one output step.
// A frame is taken in the idle state and then passes a check state before a
// burst of up to sixteen results; flush frames and priming frames but the last
// stay in the idle state, and a pass-through frame uses the idle and pass states.
// A two-entry request queue lets input arrive while results drain.
// Reset is asynchronous and active low; history needs no clearing pass.
module cubic_hermite_stream_resampler_top #(
	parameter int CHANNELS = 2,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [0:0] operation,
	input logic signed [chsr_pkg::SAMPLE_W-1:0] left_sample,
	input logic signed [chsr_pkg::SAMPLE_W-1:0] right_sample,
	output logic out_valid,
	input logic out_ready,
	output logic signed [chsr_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [chsr_pkg::SAMPLE_W-1:0] right_out,
	output logic last_of_run,
	input logic cfg_write,
	input logic [0:0] cfg_index,
	input logic [chsr_pkg::RATIO_W-1:0] cfg_data
);
	import chsr_pkg::*;

	`include "assert_macros.svh"

	logic [RATIO_W-1:0] ratio_q;
	logic [CC_W-1:0] chan_q;
	logic q_valid;
	logic q_pop;
	chsr_item_t q_item;
	logic mono;
	logic reprime;

	assign reprime = cfg_write && cfg_index == REG_RATIO;
	assign mono = (CHANNELS == 1) || (chan_q <= 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= 21'd65536;
			chan_q <= 2'd2;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RATIO: ratio_q <= cfg_data;
				REG_CHANNELS: chan_q <= cfg_data[CC_W-1:0];
				default: ratio_q <= ratio_q;
			endcase
		end
	end

	chsr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.ratio(ratio_q),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	chsr_back #(.CHANNELS(CHANNELS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.ratio(ratio_q),
		.mono(mono),
		.reprime(reprime),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_out(left_out),
		.right_out(right_out),
		.last_of_run(last_of_run)
	);

	`CHSR_ASSERT_SAME(a_pop_nonempty, clk, arst_n, q_pop, q_valid)
	`CHSR_ASSERT_SAME(a_full_nonempty, clk, arst_n, !in_ready, q_valid)
	`CHSR_ASSERT_NEXT(a_ratio_write, clk, arst_n, reprime, ratio_q == $past(cfg_data))
endmodule

>>> tb/cubic_hermite_stream_resampler_top_test.sv
module cubic_hermite_stream_resampler_top_test;
	import chsr_pkg::*;

	localparam int unsigned ONE = 32'd1 << 16;
	localparam int unsigned POS_LIMIT = 32'h1F_FFFF;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SETTLE = 120;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic last;
	} sample_pair_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [0:0] operation;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic out_valid;
	logic out_ready;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic last_of_run;
	logic cfg_write;
	logic [0:0] cfg_index;
	logic [RATIO_W-1:0] cfg_data;

	cubic_hermite_stream_resampler_top DUT (.*);

	// Model state of the resampler.
	longint taps [2][4];
	int unsigned read_pos;
	int unsigned prime_left;
	int unsigned ratio;
	int unsigned chan_count;

	sample_pair_t pending_samples [$];
	int errors = 0;
	int cycles = 0;
	int hold_off = 0;
	int burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("cubic_hermite_stream_resampler_top regression: fail");
			$finish;
		end
	end

	function automatic longint hermite(longint xm1, longint x0, longint x1, longint x2,
			int unsigned frac);
		longint a2, b2, c2, v, p;
		a2 = 3 * (x0 - x1) - xm1 + x2;
		b2 = 4 * x1 + 2 * xm1 - 5 * x0 - x2;
		c2 = x1 - xm1;
		p = longint'(frac);
		v = a2;
		v = ((v * p) >>> 16) + b2;
		v = ((v * p) >>> 16) + c2;
		v = v * p + 2 * x0 * longint'(ONE);
		return (v + longint'(ONE)) >>> 17;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clamp24(longint v);
		if (v > 64'sd8388607)
			return 24'sh7FFFFF;
		if (v < -64'sd8388608)
			return 24'sh800000;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic predict_request(logic [0:0] op, logic signed [SAMPLE_W-1:0] l,
			logic signed [SAMPLE_W-1:0] r);
		longint smp [2];
		bit mono;
		int n;
		int unsigned tap;
		int unsigned np;
		longint lv, rv;
		sample_pair_t res;
		mono = chan_count <= 1;
		n = 0;
		if (op == OP_FLUSH) begin
			prime_left = 3;
			read_pos = 0;
			return;
		end
		smp[0] = longint'(l);
		smp[1] = longint'(r);
		if (ratio == ONE) begin
			res.left = l;
			res.right = mono ? l : r;
			res.last = 1'b1;
			pending_samples.push_back(res);
			return;
		end
		if (prime_left != 0) begin
			tap = 4 - prime_left;
			for (int c = 0; c < 2; c++) begin
				if (tap == 1)
					taps[c][0] = 0;
				taps[c][tap] = smp[c];
			end
			prime_left--;
			if (prime_left != 0)
				return;
			read_pos = 0;
		end else begin
			for (int c = 0; c < 2; c++) begin
				taps[c][0] = taps[c][1];
				taps[c][1] = taps[c][2];
				taps[c][2] = taps[c][3];
				taps[c][3] = smp[c];
			end
			read_pos = (read_pos >= ONE) ? read_pos - ONE : 0;
		end
		while (read_pos < ONE && n < MAX_RESULTS) begin
			lv = hermite(taps[0][0], taps[0][1], taps[0][2], taps[0][3], read_pos);
			rv = mono ? lv : hermite(taps[1][0], taps[1][1], taps[1][2], taps[1][3], read_pos);
			res.left = clamp24(lv);
			res.right = clamp24(rv);
			res.last = 1'b0;
			pending_samples.push_back(res);
			np = read_pos + ratio;
			read_pos = (np > POS_LIMIT) ? POS_LIMIT : np;
			n++;
		end
		if (n > 0)
			pending_samples[$].last = 1'b1;
	endtask

	// Output side: the stall pattern is redrawn at random among four modes.
	initial begin
		int mode, span;
		mode = 0;
		span = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(64, 300);
			end
			span--;
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 4) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		sample_pair_t exp_s;
		if (arst_n && out_valid && out_ready) begin
			if (pending_samples.size() == 0) begin
				$error("unexpected result left_out=%0d right_out=%0d", left_out, right_out);
				errors++;
			end else begin
				exp_s = pending_samples.pop_front();
				if (left_out !== exp_s.left) begin
					$error("left_out expected %0d got %0d", exp_s.left, left_out);
					errors++;
				end
				if (right_out !== exp_s.right) begin
					$error("right_out expected %0d got %0d", exp_s.right, right_out);
					errors++;
				end
				if (last_of_run !== exp_s.last) begin
					$error("last_of_run expected %0b got %0b", exp_s.last, last_of_run);
					errors++;
				end
			end
		end
	end

	// Called just after a rising edge; returns just after the accepting edge, or after the idle gap that ends a burst.
	task automatic send_request(logic [0:0] op, logic signed [SAMPLE_W-1:0] l,
			logic signed [SAMPLE_W-1:0] r);
		int gap;
		in_valid <= 1'b1;
		operation <= op;
		left_sample <= l;
		right_sample <= r;
		do
			@(posedge clk);
		while (!in_ready);
		predict_request(op, l, r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [RATIO_W-1:0] value);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_RATIO) begin
			ratio = 32'(value);
			prime_left = 3;
			read_pos = 0;
		end else begin
			chan_count = 32'(value[1:0]);
		end
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return $signed(24'($urandom_range(0, 64))) - 24'sd32;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_frames(int count, int flush_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < flush_pct)
				send_request(OP_FLUSH, pick_sample(), pick_sample());
			else
				send_request(OP_FRAME, pick_sample(), pick_sample());
		end
	endtask

	task automatic test_unity_passthrough();
		send_request(OP_FRAME, 24'sh7FFFFF, 24'sh800000);
		send_request(OP_FRAME, 24'sh800000, 24'sh7FFFFF);
		send_request(OP_FLUSH, 24'sh123456, 24'sh654321);
		send_request(OP_FRAME, 24'sh000000, -24'sd1);
		write_reg(REG_CHANNELS, 21'd1);
		send_request(OP_FRAME, 24'sh555555, 24'shAAAAAA);
		write_reg(REG_CHANNELS, 21'd2);
	endtask

	task automatic test_extremes();
		// Full-scale steps drive the interpolation past the 24-bit range.
		write_reg(REG_RATIO, 21'd4096);
		send_request(OP_FRAME, 24'sh800000, 24'sh7FFFFF);
		send_request(OP_FRAME, 24'sh7FFFFF, 24'sh800000);
		send_request(OP_FRAME, 24'sh800000, 24'sh7FFFFF);
		send_request(OP_FRAME, 24'sh7FFFFF, 24'sh800000);
		send_request(OP_FRAME, 24'sh800000, 24'sh000000);
		send_request(OP_FLUSH, 24'sh0, 24'sh0);
		send_request(OP_FRAME, 24'sh7FFFFF, 24'sh7FFFFF);
		send_request(OP_FRAME, 24'sh800000, 24'sh800000);
		send_request(OP_FRAME, 24'sh7FFFFF, 24'sh7FFFFF);
		write_reg(REG_CHANNELS, 21'd0);
		send_request(OP_FRAME, 24'sh800000, 24'sh7FFFFF);
		write_reg(REG_CHANNELS, 21'd3);
		send_request(OP_FRAME, 24'sh7FFFFF, 24'sh800000);
		// A ratio of zero never advances; every frame after priming hits the result cap.
		write_reg(REG_RATIO, 21'd0);
		repeat (5) send_request(OP_FRAME, pick_sample(), pick_sample());
		// Largest ratio saturates the read position.
		write_reg(REG_RATIO, 21'h1FFFFF);
		repeat (6) send_request(OP_FRAME, pick_sample(), pick_sample());
	endtask

	task automatic test_random_ratios();
		int unsigned r;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: r = $urandom_range(4096, 65535);
				1: r = $urandom_range(65537, 1048576);
				2: r = (phase < 4) ? 32'd1048576 : 32'd65536;
				default: r = $urandom_range(20000, 200000);
			endcase
			write_reg(REG_RATIO, RATIO_W'(r));
			write_reg(REG_CHANNELS, RATIO_W'($urandom_range(0, 3)));
			send_frames((r < 16384) ? 20 : 55, 4);
		end
	endtask

	task automatic test_backpressure();
		write_reg(REG_RATIO, 21'd30000);
		write_reg(REG_CHANNELS, 21'd2);
		hold_off = 800;
		send_frames(40, 0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_FRAME;
		left_sample = '0;
		right_sample = '0;
		cfg_write = 1'b0;
		cfg_index = REG_RATIO;
		cfg_data = '0;
		for (int c = 0; c < 2; c++)
			for (int t = 0; t < 4; t++)
				taps[c][t] = 0;
		read_pos = 0;
		prime_left = 3;
		ratio = ONE;
		chan_count = 2;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unity_passthrough();
		test_extremes();
		test_random_ratios();
		test_backpressure();
		wait_idle();
		if (errors == 0)
			$display("cubic_hermite_stream_resampler_top regression: pass");
		else
			$display("cubic_hermite_stream_resampler_top regression: fail");
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl
rtl/chsr_pkg.sv
rtl/chsr_front.sv
rtl/chsr_lane.sv
rtl/chsr_back.sv
rtl/cubic_hermite_stream_resampler_top.sv
tb/cubic_hermite_stream_resampler_top_test.sv
